// ===== hdl/irq_dispatch_filter_with_counters_unit_macros.svh =====
// Assertion macros shared by the interrupt dispatch filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IRQ_DISPATCH_FILTER_WITH_COUNTERS_UNIT_MACROS_SVH
`define IRQ_DISPATCH_FILTER_WITH_COUNTERS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/idfc_pkg.sv =====
// Shared types and constants for the interrupt dispatch filter.
// No dependencies; imported by the counter bank and the top level.
package idfc_pkg;

    localparam int NUM_LINES_DEF = 32;
    localparam int LINE_W        = 8;
    localparam int CNT_W         = 64;
    localparam int CFG_AW        = 4;
    localparam int CFG_DW        = 32;

    localparam logic [1:0] ACT_DISPATCH = 2'd0;
    localparam logic [1:0] ACT_READ     = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    localparam logic [1:0] REG_GLOBAL_ENABLE = 2'd0;
    localparam logic [1:0] REG_LINE_MASK     = 2'd1;
    localparam logic [1:0] REG_HANDLER       = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LINE   = 3'd1,
        ST_DISABLED   = 3'd2,
        ST_MASKED     = 3'd3,
        ST_NO_HANDLER = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]        action;
        logic [LINE_W-1:0] line;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic              deliver;
        logic [CNT_W-1:0]  line_count;
        logic [CNT_W-1:0]  refused_bad_line;
        logic [CNT_W-1:0]  refused_disabled;
        logic [CNT_W-1:0]  refused_masked;
        logic [CNT_W-1:0]  refused_unhandled;
    } t_out;

    // Update request from the top level to the counter bank.
    typedef struct packed {
        logic inc;
        logic clr;
    } t_bank_op;

endpackage

// ===== hdl/idfc_count_bank.sv =====
// Per-line 64-bit delivery counters; a clear empties every entry at once.
// Depends on idfc_pkg.
module idfc_count_bank #(
    parameter int NUM_LINES = idfc_pkg::NUM_LINES_DEF,
    parameter int IDX_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [IDX_W-1:0]           i_idx,
    input  idfc_pkg::t_bank_op         i_op,
    output logic [idfc_pkg::CNT_W-1:0] o_count,
    output logic [idfc_pkg::CNT_W-1:0] o_count_inc
);
    import idfc_pkg::*;

    logic [CNT_W-1:0]     r_cnt [NUM_LINES];
    logic [NUM_LINES-1:0] r_vld;

    // An entry not written since the last clear reads as zero.
    assign o_count     = r_vld[i_idx] ? r_cnt[i_idx] : '0;
    assign o_count_inc = o_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_op.clr) begin
            r_vld <= '0;
        end else if (i_op.inc) begin
            r_vld[i_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.inc) begin
            r_cnt[i_idx] <= o_count_inc;
        end
    end

endmodule

// ===== hdl/irq_dispatch_filter_with_counters_unit.sv =====
// Top level of the interrupt dispatch filter: input register, check logic,
// denial counters, configuration registers and result register.
// Depends on idfc_pkg, idfc_count_bank and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one access:
//   dispatch a line, read a line's delivery count, or clear all counters.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per access: status, deliver flag, the line's count and the
//   four denial counters as they stand after the access.
//   Flow: a beat accepted into the input register moves to the result register
//   once that register is empty or being drained, and is offered from there.
//   Throughput: one access per cycle while the output is not stalled; checks,
//   the 32:1 count select and 64-bit increments lie between the two registers.
//   Stall: while the result register is full and stalled, the input register
//   holds and o_in_stall rises once it is occupied; no beat is dropped.
//   Reset: both registers empty, all counters zero, global_enable 1, mask
//   and handler bits 0. Configuration is written through the APB port at byte
//   addresses 0, 4, 8 (paddr[3:2]); writes at 12 to 15 are ignored, reads give 0.
`include "irq_dispatch_filter_with_counters_unit_macros.svh"
module irq_dispatch_filter_with_counters_unit #(
    parameter int NUM_LINES = idfc_pkg::NUM_LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  idfc_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output idfc_pkg::t_out              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [idfc_pkg::CFG_AW-1:0] paddr,
    input  logic [idfc_pkg::CFG_DW-1:0] pwdata,
    output logic [idfc_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import idfc_pkg::*;

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // Configuration registers
    logic              r_global_en;
    logic [31:0]       r_line_mask;
    logic [31:0]       r_handler;

    // Pipeline registers
    logic              r_in_vld;
    t_in               r_in;
    logic              r_out_vld;
    t_out              r_out;
    t_out              n_out;

    // Denial counters
    logic [CNT_W-1:0]  r_bad_total, n_bad_total;
    logic [CNT_W-1:0]  r_dis_total, n_dis_total;
    logic [CNT_W-1:0]  r_msk_total, n_msk_total;
    logic [CNT_W-1:0]  r_unh_total, n_unh_total;

    logic              w_adv;
    logic              w_in_acc;
    logic              w_line_ok;
    logic [4:0]        w_bit;
    logic [IDX_W-1:0]  w_idx;
    t_bank_op          w_op;
    logic              w_inc;
    logic              w_clr;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_count_inc;
    logic              w_cfg_wr;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_en <= 1'b1;
            r_line_mask <= '0;
            r_handler   <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_GLOBAL_ENABLE: r_global_en <= pwdata[0];
                REG_LINE_MASK:     r_line_mask <= pwdata;
                REG_HANDLER:       r_handler   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GLOBAL_ENABLE: prdata = {{(CFG_DW-1){1'b0}}, r_global_en};
            REG_LINE_MASK:     prdata = r_line_mask;
            REG_HANDLER:       prdata = r_handler;
            default:           prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // Advance when the result register is empty or being drained.
    assign w_adv       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_adv;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // ---------------- check logic ----------------
    assign w_line_ok = r_in.line < LINE_W'(NUM_LINES);
    assign w_bit     = r_in.line[4:0];
    assign w_idx     = r_in.line[IDX_W-1:0];

    always_comb begin
        n_bad_total = r_bad_total;
        n_dis_total = r_dis_total;
        n_msk_total = r_msk_total;
        n_unh_total = r_unh_total;
        w_inc       = 1'b0;
        w_clr       = 1'b0;
        n_out       = '0;
        n_out.status = ST_OK;
        case (r_in.action)
            ACT_CLEAR: begin
                w_clr       = 1'b1;
                n_bad_total = '0;
                n_dis_total = '0;
                n_msk_total = '0;
                n_unh_total = '0;
            end
            ACT_DISPATCH: begin
                if (!w_line_ok) begin
                    n_out.status = ST_BAD_LINE;
                    n_bad_total  = r_bad_total + CNT_W'(1);
                end else if (!r_global_en) begin
                    n_out.status = ST_DISABLED;
                    n_dis_total  = r_dis_total + CNT_W'(1);
                end else if (r_line_mask[w_bit]) begin
                    n_out.status = ST_MASKED;
                    n_msk_total  = r_msk_total + CNT_W'(1);
                end else if (!r_handler[w_bit]) begin
                    n_out.status = ST_NO_HANDLER;
                    n_unh_total  = r_unh_total + CNT_W'(1);
                end else begin
                    w_inc         = 1'b1;
                    n_out.deliver = 1'b1;
                end
                if (w_line_ok) begin
                    n_out.line_count = w_inc ? w_count_inc : w_count;
                end
            end
            // Read, and the unused code that behaves as one
            default: begin
                if (w_line_ok) begin
                    n_out.line_count = w_count;
                end else begin
                    n_out.status = ST_BAD_LINE;
                end
            end
        endcase
        n_out.refused_bad_line  = n_bad_total;
        n_out.refused_disabled  = n_dis_total;
        n_out.refused_masked    = n_msk_total;
        n_out.refused_unhandled = n_unh_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_total <= '0;
            r_dis_total <= '0;
            r_msk_total <= '0;
            r_unh_total <= '0;
        end else if (w_adv) begin
            r_bad_total <= n_bad_total;
            r_dis_total <= n_dis_total;
            r_msk_total <= n_msk_total;
            r_unh_total <= n_unh_total;
        end
    end

    // Commit bank updates only when the beat moves to the result register.
    assign w_op.inc = w_adv && w_inc;
    assign w_op.clr = w_adv && w_clr;

    idfc_count_bank #(
        .NUM_LINES (NUM_LINES),
        .IDX_W     (IDX_W)
    ) u_count_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_idx       (w_idx),
        .i_op        (w_op),
        .o_count     (w_count),
        .o_count_inc (w_count_inc)
    );

    // ---------------- assertions ----------------
    `IDFC_ASSERT_NOW(a_stall_needs_full, i_clk, i_rst_n, o_in_stall, r_in_vld, "input stalled while input register empty")
    `IDFC_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, w_adv && (r_in.action == ACT_CLEAR), (r_out.refused_bad_line == '0) && (r_out.refused_unhandled == '0) && (r_out.line_count == '0), "clear result not zero")
    `IDFC_ASSERT_NEXT(a_deliver_ok, i_clk, i_rst_n, w_op.inc, r_out.deliver && (r_out.status == ST_OK) && (r_out.line_count == $past(w_count) + CNT_W'(1)), "delivery result inconsistent")
    `IDFC_ASSERT_NEXT(a_bad_line_bump, i_clk, i_rst_n, w_adv && (r_in.action == ACT_DISPATCH) && !w_line_ok, r_bad_total == $past(r_bad_total) + CNT_W'(1), "bad line counter did not advance")

endmodule
